/* rtl/core/bfxm_pkg.sv */
package bfxm_pkg;

  localparam int KEY_W = 32;
  localparam int REQ_W = 2;
  localparam int BIU_W = 17;
  localparam int HCNT_W = 3;
  localparam int PARAM_W = 32;
  localparam int NUM_PARAM_REGS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_TEST = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST_ADD = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_PARAM0 = 3'd2;

  localparam logic [BIU_W-1:0] BIU_RESET = 17'd65535;
  localparam logic [HCNT_W-1:0] HCNT_RESET = 3'd4;

  typedef struct packed {
    logic load;
    logic div_load;
    logic div_step;
    logic rd;
    logic set_bit;
    logic clr_step;
    logic hit_init;
    logic hit_miss;
    logic next_hash;
  } cmd_t;

  typedef struct packed {
    logic zero_hashes;
    logic div_last;
    logic last_hash;
    logic rd_bit;
    logic clr_last;
  } sts_t;

endpackage

/* rtl/core/bfxm_ctrl.sv */
module bfxm_ctrl
  import bfxm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  sts_t             sts,
  output cmd_t             cmd,
  output logic             busy,
  output logic             done
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [REQ_W-1:0] req;
  logic [REQ_W-1:0] req_next;
  logic             done_next;
  logic             miss;

  assign busy = (state != ST_IDLE);
  assign miss = !sts.rd_bit && (req != REQ_ADD);

  always_comb begin
    cmd = '0;
    state_next = state;
    req_next = req;
    done_next = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cmd.hit_init = 1'b1;
          req_next = req_type;
          if (req_type == REQ_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (sts.zero_hashes) begin
            done_next = (req_type != REQ_ADD);
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd.div_load = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.hit_miss = miss;
        cmd.set_bit = (req != REQ_TEST);
        if ((miss && (req == REQ_TEST)) || sts.last_hash) begin
          done_next = (req != REQ_ADD);
          state_next = ST_IDLE;
        end else begin
          cmd.next_hash = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      req <= REQ_TEST;
      done <= 1'b0;
    end else begin
      state <= state_next;
      req <= req_next;
      done <= done_next;
    end
  end

endmodule

/* rtl/core/bfxm_datapath.sv */
module bfxm_datapath
  import bfxm_pkg::*;
#(
  parameter int STORE_BITS = 65536,
  parameter int MAX_HASHES = 4,
  parameter int HASH_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [KEY_W-1:0]      key_hash,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  found
);

  localparam int AW = (STORE_BITS > 1) ? $clog2(STORE_BITS) : 1;
  localparam int MW = $clog2(STORE_BITS + 1);
  localparam int CMPW = (MW > BIU_W) ? MW : BIU_W;
  localparam int DW = (HASH_WIDTH < KEY_W) ? HASH_WIDTH : KEY_W;
  localparam int DCW = $clog2(DW);
  localparam int CW = $clog2(MAX_HASHES + 1);

  logic [BIU_W-1:0]   bits_in_use;
  logic [HCNT_W-1:0]  hash_count;
  logic [PARAM_W-1:0] hash_param [NUM_PARAM_REGS];

  logic [KEY_W-1:0]   key;
  logic [CW-1:0]      hidx;
  logic [CW-1:0]      hidx_inc;
  logic [CW-1:0]      n_active;
  logic [MW-1:0]      modulus;
  logic [CMPW-1:0]    biu_ext;
  logic [PARAM_W-1:0] mask;

  logic [DW-1:0]      dvd;
  logic [MW-1:0]      rem;
  logic [MW:0]        trial;
  logic [MW:0]        mod_ext;
  logic [MW-1:0]      rem_next;
  logic [DCW-1:0]     dcnt;

  logic [AW-1:0]      clr_addr;
  logic               mem [STORE_BITS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               rd_bit;
  logic               hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BIU_RESET;
      hash_count <= HCNT_RESET;
      for (int k = 0; k < NUM_PARAM_REGS; k++) begin
        hash_param[k] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BITS_IN_USE) begin
        bits_in_use <= cfg_data[BIU_W-1:0];
      end
      if (cfg_index == CFG_HASH_COUNT) begin
        hash_count <= cfg_data[HCNT_W-1:0];
      end
      for (int k = 0; k < NUM_PARAM_REGS; k++) begin
        if ((k < MAX_HASHES) && (cfg_index == CFG_HASH_PARAM0 + CFG_IDX_W'(k))) begin
          hash_param[k] <= cfg_data[PARAM_W-1:0];
        end
      end
    end
  end

  assign biu_ext = CMPW'(bits_in_use);

  always_comb begin
    if (bits_in_use == '0) begin
      modulus = MW'(1);
    end else if (biu_ext > CMPW'(STORE_BITS)) begin
      modulus = MW'(STORE_BITS);
    end else begin
      modulus = biu_ext[MW-1:0];
    end
  end

  always_comb begin
    if (int'(hash_count) > MAX_HASHES) begin
      n_active = CW'(MAX_HASHES);
    end else begin
      n_active = CW'(hash_count);
    end
  end

  always_comb begin
    mask = '0;
    for (int k = 0; k < NUM_PARAM_REGS; k++) begin
      if ((k < MAX_HASHES) && (int'(hidx) == k)) begin
        mask = hash_param[k];
      end
    end
  end

  assign hidx_inc = hidx + CW'(1);

  assign mod_ext = {1'b0, modulus};
  assign trial = {rem, dvd[DW-1]};

  always_comb begin
    if (trial >= mod_ext) begin
      rem_next = MW'(trial - mod_ext);
    end else begin
      rem_next = trial[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= key_hash;
    end
    if (cmd.div_load) begin
      dvd <= DW'(key ^ mask);
      rem <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= rem_next;
      dcnt <= dcnt + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hidx <= '0;
      clr_addr <= '0;
      hit <= 1'b1;
    end else begin
      if (cmd.load) begin
        hidx <= '0;
      end else if (cmd.next_hash) begin
        hidx <= hidx_inc;
      end
      if (cmd.clr_step) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + AW'(1);
      end
      if (cmd.hit_init) begin
        hit <= 1'b1;
      end else if (cmd.hit_miss) begin
        hit <= 1'b0;
      end
    end
  end

  assign mem_we = cmd.set_bit || cmd.clr_step;
  assign mem_waddr = cmd.clr_step ? clr_addr : rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= !cmd.clr_step;
    end
    if (cmd.rd) begin
      rd_bit <= mem[rem[AW-1:0]];
    end
  end

  assign sts.zero_hashes = (n_active == '0);
  assign sts.div_last = (dcnt == DCW'(DW - 1));
  assign sts.last_hash = (hidx_inc == n_active);
  assign sts.rd_bit = rd_bit;
  assign sts.clr_last = (clr_addr == AW'(STORE_BITS - 1));

  assign found = hit;

endmodule

/* rtl/core/bloom_filter_xor_mod.sv */
// A test or test-and-add strobes done once its active hashes are checked, with W the hash width
// (at most 32); a test stops at its first miss.
// Start is taken only while idle, so requests never overlap; the remainder is bit-serial in W.
// A clear request, and reset, sweep the store one bit a cycle, with busy high for the sweep.
// Reset is synchronous and active high; it restores the registers and starts that sweep.
// done lasts one cycle and the receiver cannot stall it.
module bloom_filter_xor_mod
  import bfxm_pkg::*;
#(
  parameter int STORE_BITS = 65536,
  parameter int MAX_HASHES = 4,
  parameter int HASH_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [KEY_W-1:0]      key_hash,
  output logic                  done,
  output logic                  found,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfxm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  bfxm_datapath #(
    .STORE_BITS (STORE_BITS),
    .MAX_HASHES (MAX_HASHES),
    .HASH_WIDTH (HASH_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_hash  (key_hash),
    .cmd       (cmd),
    .sts       (sts),
    .found     (found)
  );

endmodule

/* sim/bloom_filter_xor_mod_tb.sv */
module bloom_filter_xor_mod_tb;
  import bfxm_pkg::*;

  localparam int STORE_BITS = 65536;
  localparam int MAX_HASHES = 4;
  localparam int RAND_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 146;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 =
    CFG_IDX_W'(CFG_HASH_PARAM0 + NUM_PARAM_REGS);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = CFG_IDX_W'(CFG_SPARE0 + 1);

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
  } bf_item_t;

  logic clk = 1'b0;
  logic rst;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] req_type = REQ_TEST;
  logic [KEY_W-1:0] key_hash = '0;
  logic done;
  logic found;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bf_item_t pending_items[$];
  bf_item_t next_item;
  logic [KEY_W-1:0] added_keys[$];
  bit expected_found[$];

  bit bloom_store[STORE_BITS];
  logic [BIU_W-1:0] biu_cfg;
  logic [HCNT_W-1:0] hcnt_cfg;
  logic [PARAM_W-1:0] mask_cfg[NUM_PARAM_REGS];

  int items_queued = 0;
  int items_accepted = 0;
  int errors = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit lookup_hit;

  bloom_filter_xor_mod u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .key_hash  (key_hash),
    .done      (done),
    .found     (found),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit apply_request(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key);
    int unsigned modv;
    int unsigned nh;
    int unsigned idx;
    bit all_set;
    all_set = 1'b1;
    if (req == REQ_CLEAR) begin
      foreach (bloom_store[j]) bloom_store[j] = 1'b0;
      return 1'b0;
    end
    modv = biu_cfg;
    if (modv == 0) modv = 1;
    if (modv > STORE_BITS) modv = STORE_BITS;
    nh = hcnt_cfg;
    if (nh > MAX_HASHES) nh = MAX_HASHES;
    for (int i = 0; i < nh; i++) begin
      idx = (key ^ mask_cfg[i]) % modv;
      if (req != REQ_ADD && !bloom_store[idx]) begin
        all_set = 1'b0;
        if (req == REQ_TEST) break;
      end
      if (req != REQ_TEST) bloom_store[idx] = 1'b1;
    end
    return all_set;
  endfunction

  // accept, predict, then load the next item
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        lookup_hit = apply_request(req_type, key_hash);
        if (req_type == REQ_TEST || req_type == REQ_TEST_ADD) begin
          expected_found.push_back(lookup_hit);
        end
        items_accepted++;
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
          next_item = pending_items.pop_front();
          start <= 1'b1;
          req_type <= next_item.req;
          key_hash <= next_item.key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_found.size() == 0) begin
        $error("unexpected result: found %0b with no lookup pending", found);
        errors++;
      end else if (found !== expected_found[0]) begin
        $error("found mismatch: expected %0b, actual %0b", expected_found[0], found);
        errors++;
        void'(expected_found.pop_front());
      end else begin
        void'(expected_found.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_item(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key);
    bf_item_t it;
    it.req = req;
    it.key = key;
    pending_items.push_back(it);
    items_queued++;
    if (req == REQ_ADD || req == REQ_TEST_ADD) begin
      added_keys.push_back(key);
      if (added_keys.size() > 64) void'(added_keys.pop_front());
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_BITS_IN_USE) begin
      biu_cfg = data[BIU_W-1:0];
    end else if (idx == CFG_HASH_COUNT) begin
      hcnt_cfg = data[HCNT_W-1:0];
    end else if (idx >= CFG_HASH_PARAM0 && idx < CFG_SPARE0) begin
      mask_cfg[idx - CFG_HASH_PARAM0] = data;
    end
    @(posedge clk);
  endtask

  // hold until every item is in, every lookup answered and the block is idle
  task automatic drain();
    while (items_accepted != items_queued) @(posedge clk);
    while (expected_found.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [PARAM_W-1:0] random_mask();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    int r;
    int clears_left;
    int clear_at;
    logic [KEY_W-1:0] key;
    logic [REQ_W-1:0] req;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_BITS_IN_USE;
    cfg_data = '0;
    biu_cfg = BIU_RESET;
    hcnt_cfg = HCNT_RESET;
    foreach (mask_cfg[k]) mask_cfg[k] = '0;
    foreach (bloom_store[j]) bloom_store[j] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    push_item(REQ_TEST, 32'h0000_0000);
    push_item(REQ_ADD, 32'h0000_0000);
    push_item(REQ_TEST, 32'h0000_0000);
    push_item(REQ_TEST_ADD, 32'hFFFF_FFFF);
    push_item(REQ_TEST, 32'hFFFF_FFFF);
    push_item(REQ_ADD, 32'h8000_0000);
    push_item(REQ_TEST_ADD, 32'h8000_0000);
    push_item(REQ_TEST, 32'h7FFF_FFFF);
    push_item(REQ_CLEAR, 32'hA5A5_A5A5);
    push_item(REQ_TEST, 32'h0000_0000);
    drain();

    write_reg(CFG_BITS_IN_USE, 32'd0);
    write_reg(CFG_HASH_COUNT, 32'd0);
    push_item(REQ_TEST, 32'h0000_1234);
    push_item(REQ_TEST_ADD, 32'hFFFF_FFFF);
    push_item(REQ_ADD, 32'h0000_0005);
    drain();

    write_reg(CFG_HASH_COUNT, 32'hFFFF_FFFF);
    push_item(REQ_TEST, 32'h0000_0000);
    push_item(REQ_ADD, 32'h0000_0009);
    push_item(REQ_TEST, 32'hFFFF_FFFF);
    drain();

    write_reg(CFG_BITS_IN_USE, 32'hFFFF_FFFF);
    write_reg(CFG_HASH_COUNT, 32'd4);
    write_reg(CFG_HASH_PARAM0, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + 1), 32'h0000_0000);
    write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + 2), 32'h8000_0000);
    write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + 3), 32'h0000_FFFF);
    write_reg(CFG_SPARE0, $urandom);
    write_reg(CFG_SPARE1, $urandom);
    push_item(REQ_TEST_ADD, 32'h0000_0000);
    push_item(REQ_TEST_ADD, 32'h0000_0000);
    push_item(REQ_TEST, 32'hFFFF_FFFF);
    push_item(REQ_ADD, 32'h7FFF_0000);
    drain();

    write_reg(CFG_BITS_IN_USE, 32'd2);
    write_reg(CFG_HASH_PARAM0, 32'h0000_0000);
    write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + 2), 32'h0000_0000);
    write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + 3), 32'h0000_0000);
    push_item(REQ_TEST_ADD, 32'h0000_0001);
    push_item(REQ_TEST, 32'h0000_0001);
    drain();

    clears_left = 3;
    for (int p = 0; p < RAND_PHASES; p++) begin
      r = $urandom_range(9);
      if (r < 6) write_reg(CFG_BITS_IN_USE, $urandom_range(400, 1));
      else if (r < 8) write_reg(CFG_BITS_IN_USE, $urandom_range(STORE_BITS, 1));
      else if (r == 8) begin
        case ($urandom_range(3))
          0: write_reg(CFG_BITS_IN_USE, 32'd0);
          1: write_reg(CFG_BITS_IN_USE, 32'd1);
          2: write_reg(CFG_BITS_IN_USE, STORE_BITS);
          default: write_reg(CFG_BITS_IN_USE, STORE_BITS - 1);
        endcase
      end else write_reg(CFG_BITS_IN_USE, $urandom);
      if ($urandom_range(3) == 0) write_reg(CFG_HASH_COUNT, $urandom);
      else write_reg(CFG_HASH_COUNT, $urandom_range(4, 1));
      for (int k = 0; k < NUM_PARAM_REGS; k++) begin
        if ($urandom_range(1) == 0) begin
          write_reg(CFG_IDX_W'(CFG_HASH_PARAM0 + k), random_mask());
        end
      end

      steady = (p == 5);
      clear_at = -1;
      if (clears_left > 0 && $urandom_range(3) == 0) begin
        clear_at = $urandom_range(ITEMS_PER_PHASE - 1);
        clears_left--;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (n == clear_at) req = REQ_CLEAR;
        else if (r < 40) req = REQ_TEST;
        else if (r < 75) req = REQ_ADD;
        else req = REQ_TEST_ADD;
        if (added_keys.size() != 0 && $urandom_range(99) < 40) begin
          key = added_keys[$urandom_range(added_keys.size() - 1)];
        end else begin
          key = $urandom;
        end
        push_item(req, key);
      end
      drain();
      steady = 1'b0;
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
